[rtl/core/pn3d_pkg.sv]
// Shared constants and codes for the 3-D gradient noise block.
`default_nettype none
package pn3d_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int COORD_W         = 32;
  localparam int TBL_DW          = 8;
  localparam int OUT_W           = 18;
  localparam int OUT_FRAC        = 16;
  localparam int OUT_MAX         = 131071;
  localparam int OUT_MIN         = -131072;
  localparam int IN_TDATA_W      = 112;
  localparam int OUT_TDATA_W     = 24;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } action_t;

endpackage
`default_nettype wire

[rtl/core/perlin_noise_3d.sv]
// Three-dimensional improved gradient noise with a loadable permutation table.
// An evaluate item passes stage registers s1 to s7 and then the output register.
// Throughput: one item per cycle while the output is not stalled; eight register stages, table replicated so
// every table lookup of an item has its own read port.
// A stalled result stalls the pipeline only when the last stage also holds a result.
// Reset (rst_n low, synchronous) clears stage and output valid bits; table is not cleared.
`default_nettype none
module perlin_noise_3d
  import pn3d_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [7:0] table_index, [15:8] table_value, [47:16] coord_x, [79:48] coord_y,
  // [111:80] coord_z
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] action
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [17:0] noise_value, [23:18] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int F     = FRAC_BITS;
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int GW    = F + 3;
  localparam int QW    = F + 4;
  localparam int EW    = GW + 16;
  localparam int NCOPY = 7;
  localparam int SH_R  = (F >= OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam int SH_L  = (F >= OUT_FRAC) ? 0 : OUT_FRAC - F;

  localparam logic signed [GW-1:0] FIX_ONE = GW'(1) <<< F;
  localparam logic [QW-1:0] K6      = QW'(6);
  localparam logic [QW-1:0] K15     = QW'(15);
  localparam logic [QW-1:0] K10_ONE = QW'(10) << F;
  localparam logic signed [EW-1:0] SAT_HI = EW'(OUT_MAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(OUT_MIN);

  function automatic logic signed [GW-1:0] lerp_fx(input logic [F-1:0] t,
                                                   input logic signed [GW-1:0] a,
                                                   input logic signed [GW-1:0] b);
    logic signed [GW:0]      d;
    logic signed [F+GW+1:0]  p;
    logic signed [GW+1:0]    ps;
    logic signed [GW+1:0]    s;
    d  = $signed({b[GW-1], b}) - $signed({a[GW-1], a});
    p  = $signed({1'b0, t}) * d;
    ps = p[F+GW+1:F];
    s  = ps + $signed({{2{a[GW-1]}}, a});
    return s[GW-1:0];
  endfunction

  function automatic logic signed [GW-1:0] grad_fx(input logic [3:0] h,
                                                   input logic signed [GW-1:0] x,
                                                   input logic signed [GW-1:0] y,
                                                   input logic signed [GW-1:0] z);
    logic signed [GW-1:0] gu;
    logic signed [GW-1:0] gv;
    gu = (h < 4'd8) ? x : y;
    gv = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    gu = h[0] ? -gu : gu;
    gv = h[1] ? -gv : gv;
    return gu + gv;
  endfunction

  logic adv;
  logic in_acc;

  // Table copies: each one is written when a load item passes the stage that reads it.
  logic          wr_en   [NCOPY];
  logic [AW-1:0] wr_addr [NCOPY];
  logic [TBL_DW-1:0] wr_data [NCOPY];
  logic [AW-1:0] rd_a0   [NCOPY];
  logic [AW-1:0] rd_a1   [NCOPY];
  logic [TBL_DW-1:0] rd_q0_r [NCOPY];
  logic [TBL_DW-1:0] rd_q1_r [NCOPY];

  for (genvar c = 0; c < NCOPY; c++) begin : g_copy
    logic [TBL_DW-1:0] mem [TABLE_DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en[c]) begin
        mem[wr_addr[c]] <= wr_data[c];
      end
      if (adv) begin
        rd_q0_r[c] <= mem[rd_a0[c]];
        rd_q1_r[c] <= mem[rd_a1[c]];
      end
    end
  end

  // Stage registers.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r;
  logic s1_eval_r, s2_eval_r, s3_eval_r, s4_eval_r, s5_eval_r, s6_eval_r, s7_eval_r;
  logic [AW-1:0] s1_idx_r, s2_idx_r;
  logic [TBL_DW-1:0] s1_val_r, s2_val_r;
  logic [F-1:0]  s1_fx_r, s1_fy_r, s1_fz_r;
  logic [F-1:0]  s2_fx_r, s2_fy_r, s2_fz_r;
  logic [F-1:0]  s3_fx_r, s3_fy_r, s3_fz_r;
  logic [AW-1:0] s1_cy_r, s1_cz_r, s2_cz_r;
  logic [F-1:0]  s2_t2x_r, s2_t2y_r, s2_t2z_r;
  logic [F-1:0]  s3_t3x_r, s3_t3y_r, s3_t3z_r;
  logic [QW-1:0] s3_qx_r, s3_qy_r, s3_qz_r;
  logic [F-1:0]  s4_u_r, s4_v_r, s4_w_r;
  logic [F-1:0]  s5_v_r, s5_w_r, s6_w_r;
  logic signed [GW-1:0] s4_g_r [8];
  logic signed [GW-1:0] s5_l_r [4];
  logic signed [GW-1:0] s6_m_r [2];
  logic signed [GW-1:0] s7_r_r;
  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  assign adv       = !(s7_vld_r && s7_eval_r && out_valid_r && !out_tready);
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // Stage 0 fields.
  logic [AW-1:0] in_cx, in_cy, in_cz;
  assign in_cx = in_tdata[16+F+AW-1:16+F];
  assign in_cy = in_tdata[48+F+AW-1:48+F];
  assign in_cz = in_tdata[80+F+AW-1:80+F];

  // Stage 1/2 hash sums.
  logic [AW-1:0] h_a, h_b, h_aa, h_ab, h_ba, h_bb;
  assign h_a  = rd_q0_r[0][AW-1:0] + s1_cy_r;
  assign h_b  = rd_q1_r[0][AW-1:0] + s1_cy_r;
  assign h_aa = rd_q0_r[1][AW-1:0] + s2_cz_r;
  assign h_ab = rd_q1_r[1][AW-1:0] + s2_cz_r;
  assign h_ba = rd_q0_r[2][AW-1:0] + s2_cz_r;
  assign h_bb = rd_q1_r[2][AW-1:0] + s2_cz_r;

  always_comb begin
    rd_a0[0] = in_cx;        rd_a1[0] = in_cx + AW'(1);
    rd_a0[1] = h_a;          rd_a1[1] = h_a + AW'(1);
    rd_a0[2] = h_b;          rd_a1[2] = h_b + AW'(1);
    rd_a0[3] = h_aa;         rd_a1[3] = h_aa + AW'(1);
    rd_a0[4] = h_ba;         rd_a1[4] = h_ba + AW'(1);
    rd_a0[5] = h_ab;         rd_a1[5] = h_ab + AW'(1);
    rd_a0[6] = h_bb;         rd_a1[6] = h_bb + AW'(1);
    wr_en[0]   = in_acc && (action_t'(in_tuser) == ACT_LOAD);
    wr_addr[0] = in_tdata[AW-1:0];
    wr_data[0] = in_tdata[15:8];
    for (int c = 1; c < NCOPY; c++) begin
      if (c < 3) begin
        wr_en[c]   = adv && s1_vld_r && !s1_eval_r;
        wr_addr[c] = s1_idx_r;
        wr_data[c] = s1_val_r;
      end else begin
        wr_en[c]   = adv && s2_vld_r && !s2_eval_r;
        wr_addr[c] = s2_idx_r;
        wr_data[c] = s2_val_r;
      end
    end
  end

  // Fade arithmetic.
  logic [2*F-1:0] sq_x, sq_y, sq_z, cu_x, cu_y, cu_z;
  logic [QW-1:0]  q_x, q_y, q_z;
  logic [2*F+QW-1:0] fd_x, fd_y, fd_z;
  assign sq_x = s1_fx_r * s1_fx_r;
  assign sq_y = s1_fy_r * s1_fy_r;
  assign sq_z = s1_fz_r * s1_fz_r;
  assign cu_x = s2_t2x_r * s2_fx_r;
  assign cu_y = s2_t2y_r * s2_fy_r;
  assign cu_z = s2_t2z_r * s2_fz_r;
  assign q_x  = QW'(s2_t2x_r) * K6 + K10_ONE - QW'(s2_fx_r) * K15;
  assign q_y  = QW'(s2_t2y_r) * K6 + K10_ONE - QW'(s2_fy_r) * K15;
  assign q_z  = QW'(s2_t2z_r) * K6 + K10_ONE - QW'(s2_fz_r) * K15;
  assign fd_x = (2*F+QW)'(s3_t3x_r) * (2*F+QW)'(s3_qx_r);
  assign fd_y = (2*F+QW)'(s3_t3y_r) * (2*F+QW)'(s3_qy_r);
  assign fd_z = (2*F+QW)'(s3_t3z_r) * (2*F+QW)'(s3_qz_r);

  // Gradients.
  logic signed [GW-1:0] gx0, gy0, gz0, gx1, gy1, gz1;
  logic signed [GW-1:0] g_n [8];
  assign gx0 = $signed({3'b000, s3_fx_r});
  assign gy0 = $signed({3'b000, s3_fy_r});
  assign gz0 = $signed({3'b000, s3_fz_r});
  assign gx1 = gx0 - FIX_ONE;
  assign gy1 = gy0 - FIX_ONE;
  assign gz1 = gz0 - FIX_ONE;
  always_comb begin
    g_n[0] = grad_fx(rd_q0_r[3][3:0], gx0, gy0, gz0);
    g_n[1] = grad_fx(rd_q0_r[4][3:0], gx1, gy0, gz0);
    g_n[2] = grad_fx(rd_q0_r[5][3:0], gx0, gy1, gz0);
    g_n[3] = grad_fx(rd_q0_r[6][3:0], gx1, gy1, gz0);
    g_n[4] = grad_fx(rd_q1_r[3][3:0], gx0, gy0, gz1);
    g_n[5] = grad_fx(rd_q1_r[4][3:0], gx1, gy0, gz1);
    g_n[6] = grad_fx(rd_q1_r[5][3:0], gx0, gy1, gz1);
    g_n[7] = grad_fx(rd_q1_r[6][3:0], gx1, gy1, gz1);
  end

  // Output scaling with floor and saturation.
  logic signed [EW-1:0] res_ext, res_scl, res_sat;
  always_comb begin
    res_ext = {{(EW-GW){s7_r_r[GW-1]}}, s7_r_r};
    res_scl = (res_ext >>> SH_R) <<< SH_L;
    priority if (res_scl > SAT_HI) begin
      res_sat = SAT_HI;
    end else if (res_scl < SAT_LO) begin
      res_sat = SAT_LO;
    end else begin
      res_sat = res_scl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0; s2_vld_r <= 1'b0; s3_vld_r <= 1'b0; s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0; s6_vld_r <= 1'b0; s7_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r; s3_vld_r <= s2_vld_r; s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r; s6_vld_r <= s5_vld_r; s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_eval_r <= (action_t'(in_tuser) == ACT_EVAL);
      s1_idx_r  <= in_tdata[AW-1:0];
      s1_val_r  <= in_tdata[15:8];
      s1_fx_r   <= in_tdata[16+F-1:16];
      s1_fy_r   <= in_tdata[48+F-1:48];
      s1_fz_r   <= in_tdata[80+F-1:80];
      s1_cy_r   <= in_cy;
      s1_cz_r   <= in_cz;

      s2_eval_r <= s1_eval_r;
      s2_idx_r  <= s1_idx_r;
      s2_val_r  <= s1_val_r;
      s2_cz_r   <= s1_cz_r;
      s2_fx_r   <= s1_fx_r; s2_fy_r <= s1_fy_r; s2_fz_r <= s1_fz_r;
      s2_t2x_r  <= sq_x[2*F-1:F];
      s2_t2y_r  <= sq_y[2*F-1:F];
      s2_t2z_r  <= sq_z[2*F-1:F];

      s3_eval_r <= s2_eval_r;
      s3_fx_r   <= s2_fx_r; s3_fy_r <= s2_fy_r; s3_fz_r <= s2_fz_r;
      s3_t3x_r  <= cu_x[2*F-1:F];
      s3_t3y_r  <= cu_y[2*F-1:F];
      s3_t3z_r  <= cu_z[2*F-1:F];
      s3_qx_r   <= q_x; s3_qy_r <= q_y; s3_qz_r <= q_z;

      s4_eval_r <= s3_eval_r;
      s4_u_r    <= fd_x[2*F-1:F];
      s4_v_r    <= fd_y[2*F-1:F];
      s4_w_r    <= fd_z[2*F-1:F];
      for (int i = 0; i < 8; i++) begin
        s4_g_r[i] <= g_n[i];
      end

      s5_eval_r <= s4_eval_r;
      s5_v_r    <= s4_v_r;
      s5_w_r    <= s4_w_r;
      for (int i = 0; i < 4; i++) begin
        s5_l_r[i] <= lerp_fx(s4_u_r, s4_g_r[2*i], s4_g_r[2*i+1]);
      end

      s6_eval_r <= s5_eval_r;
      s6_w_r    <= s5_w_r;
      s6_m_r[0] <= lerp_fx(s5_v_r, s5_l_r[0], s5_l_r[1]);
      s6_m_r[1] <= lerp_fx(s5_v_r, s5_l_r[2], s5_l_r[3]);

      s7_eval_r <= s6_eval_r;
      s7_r_r    <= lerp_fx(s6_w_r, s6_m_r[0], s6_m_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s7_vld_r && s7_eval_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s7_vld_r && s7_eval_r) begin
      out_data_r <= res_sat[OUT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_data_r};

endmodule
`default_nettype wire

[rtl/core/pn3d_checker.sv]
// Port-level assertions for the noise block, bound to its top level.
`default_nettype none
module pn3d_checker
  import pn3d_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // No result may be pending right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With the output slot empty the block must take items.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Pad bits above the noise value stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_W] == '0)
    else $error("nonzero pad bits");

  // A load item accepted while no result is pending; the past in_tready term always holds, so this cannot fail.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (action_t'(in_tuser) == ACT_LOAD) && !out_tvalid
      |=> !out_tvalid || $past(in_tready))
    else $error("unexpected result");

endmodule

bind perlin_noise_3d pn3d_checker u_pn3d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
